FILE: sv/rppg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the color wheel function of the rainbow generator
// no dependencies

package rppg_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int CNT_W       = 7;   // pixel count, holds the full ring size
    localparam int IDX_W       = 6;   // pixel index
    localparam int FRAME_W     = 11;
    localparam int COLOR_W     = 8;
    localparam int DIV_STEPS   = 8;
    localparam int DIV_CNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIXELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD     = 1'd1;

    localparam logic [CNT_W-1:0] NUM_PIXELS_RESET = 7'd64;

    localparam logic [FRAME_W-1:0] RUN_PLAIN_LAST  = FRAME_W'(256 - 1);
    localparam logic [FRAME_W-1:0] RUN_SPREAD_LAST = FRAME_W'(256 * 5 - 1);

    localparam logic [COLOR_W-1:0] SEG_ONE  = 8'd85;
    localparam logic [COLOR_W-1:0] SEG_TWO  = 8'd170;
    localparam logic [COLOR_W-1:0] FULL_ON  = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic start;     // take a request, set up the frame
        logic div_step;  // one quotient bit
        logic load;      // write the pixel into the output register
        logic advance;   // move to the next pixel
        logic finish;    // update the frame counter
    } t_cmd;

    typedef struct packed {
        logic spread_cfg;  // configured mode, used when a request is taken
        logic spread;      // mode latched for the frame in progress
        logic div_last;
        logic out_free;
        logic pix_last;
    } t_status;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    function automatic t_rgb color_wheel(input logic [COLOR_W-1:0] hue);
        t_rgb               c;
        logic [COLOR_W-1:0] p;
        logic [COLOR_W:0]   p3;
        p = FULL_ON - hue;
        if (p < SEG_ONE) begin
            // first segment, p itself
        end else if (p < SEG_TWO) begin
            p = p - SEG_ONE;
        end else begin
            p = p - SEG_TWO;
        end
        p3 = {p, 1'b0} + {1'b0, p};
        if (FULL_ON - hue < SEG_ONE) begin
            c.red   = FULL_ON - p3[COLOR_W-1:0];
            c.green = '0;
            c.blue  = p3[COLOR_W-1:0];
        end else if (FULL_ON - hue < SEG_TWO) begin
            c.red   = '0;
            c.green = p3[COLOR_W-1:0];
            c.blue  = FULL_ON - p3[COLOR_W-1:0];
        end else begin
            c.red   = p3[COLOR_W-1:0];
            c.green = FULL_ON - p3[COLOR_W-1:0];
            c.blue  = '0;
        end
        return c;
    endfunction

endpackage

FILE: sv/rppg_req_if.sv
`timescale 1ns / 1ps
// frame request channel: valid, ready and the restart flag
// no dependencies

interface rppg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

FILE: sv/rppg_pix_if.sv
`timescale 1ns / 1ps
// pixel result channel: valid, ready and one pixel color with its flags
// no dependencies

interface rppg_pix_if;
    logic       valid;
    logic       ready;
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    logic       run_done;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output last_pixel, output run_done, input ready);
    modport sink   (input valid, input pixel_index, input red, input green,
                    input blue, input last_pixel, input run_done, output ready);
endinterface

FILE: sv/rainbow_pixel_pattern_generator.sv
`timescale 1ns / 1ps
// Rainbow color-wheel generator for an LED ring. Each request on i_req is one
// frame and yields one pixel result per pixel in use on o_pix, in pixel order,
// the last one flagged last_pixel; every pixel of the final frame of a run
// carries run_done. In spread mode the hue of each pixel is formed by a serial
// divider that yields one quotient bit per cycle; a stall on o_pix holds each
// pixel until the output register is free.
// The next request is taken once the last pixel is in the output register.
// Config writes go through i_cfg_we / i_cfg_idx / i_cfg_data: index 0 is the
// pixel count, index 1 the spread mode; write them between frames only.

module rainbow_pixel_pattern_generator #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rppg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rppg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rppg_req_if.sink                        i_req,
    rppg_pix_if.source                      o_pix
);

    rppg_pkg::t_cmd    cmd;
    rppg_pkg::t_status status;

    rppg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rppg_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_restart     (i_req.restart),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_pix_ready   (o_pix.ready),
        .o_pix_valid   (o_pix.valid),
        .o_pixel_index (o_pix.pixel_index),
        .o_red         (o_pix.red),
        .o_green       (o_pix.green),
        .o_blue        (o_pix.blue),
        .o_last_pixel  (o_pix.last_pixel),
        .o_run_done    (o_pix.run_done)
    );

endmodule

FILE: sv/rppg_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the rainbow generator
// depends on rppg_pkg

module rppg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  rppg_pkg::t_status i_status,
    output rppg_pkg::t_cmd    o_cmd
);

    rppg_pkg::t_state r_state;
    rppg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rppg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            rppg_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_status.spread_cfg ? rppg_pkg::ST_DIV : rppg_pkg::ST_LOAD;
                end
            end
            rppg_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = rppg_pkg::ST_LOAD;
                end
            end
            rppg_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.pix_last) begin
                        o_cmd.finish = 1'b1;
                        n_state = rppg_pkg::ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state = i_status.spread ? rppg_pkg::ST_DIV : rppg_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = rppg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/rppg_datapath.sv
`timescale 1ns / 1ps
// datapath: config registers, frame counter, pixel counter, serial divider,
// color wheel and the output register; depends on rppg_pkg

module rppg_datapath #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rppg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rppg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_restart,
    input  rppg_pkg::t_cmd                   i_cmd,
    output rppg_pkg::t_status                o_status,
    input  logic                             i_pix_ready,
    output logic                             o_pix_valid,
    output logic [rppg_pkg::IDX_W-1:0]       o_pixel_index,
    output logic [rppg_pkg::COLOR_W-1:0]     o_red,
    output logic [rppg_pkg::COLOR_W-1:0]     o_green,
    output logic [rppg_pkg::COLOR_W-1:0]     o_blue,
    output logic                             o_last_pixel,
    output logic                             o_run_done
);

    localparam logic [rppg_pkg::CNT_W-1:0] MaxCnt = rppg_pkg::CNT_W'(MAX_PIXELS);

    logic [rppg_pkg::CNT_W-1:0]     r_cfg_num;
    logic                           r_cfg_spread;
    logic [rppg_pkg::FRAME_W-1:0]   r_frame;
    logic [rppg_pkg::CNT_W-1:0]     r_n;
    logic                           r_spread;
    logic                           r_done;
    logic [rppg_pkg::IDX_W-1:0]     r_pix;
    logic [rppg_pkg::IDX_W-1:0]     r_rem;
    logic [rppg_pkg::COLOR_W-1:0]   r_q;
    logic [rppg_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                           r_out_valid;
    logic [rppg_pkg::IDX_W-1:0]     r_out_idx;
    rppg_pkg::t_rgb                 r_out_rgb;
    logic                           r_out_last;
    logic                           r_out_done;

    logic [rppg_pkg::CNT_W-1:0]     n_clamp;
    logic [rppg_pkg::FRAME_W-1:0]   n_frame_start;
    logic                           n_done_start;
    logic [rppg_pkg::IDX_W:0]       rem2;
    logic                           div_ge;
    logic [rppg_pkg::IDX_W:0]       rem_sub;
    logic [rppg_pkg::IDX_W-1:0]     pix_next;
    logic                           pix_last;
    logic [rppg_pkg::COLOR_W-1:0]   hue_base;
    logic [rppg_pkg::COLOR_W-1:0]   hue;
    logic                           out_free;

    // a count of zero acts as one, above the ring size it saturates
    always_comb begin
        priority if (r_cfg_num == '0) begin
            n_clamp = rppg_pkg::CNT_W'(1);
        end else if (r_cfg_num > MaxCnt) begin
            n_clamp = MaxCnt;
        end else begin
            n_clamp = r_cfg_num;
        end
    end

    assign n_frame_start = i_restart ? '0 : r_frame;
    assign n_done_start  = r_cfg_spread ? (n_frame_start >= rppg_pkg::RUN_SPREAD_LAST)
                                        : (n_frame_start >= rppg_pkg::RUN_PLAIN_LAST);

    // restoring divide of pix*256 by n, quotient fits in 8 bits since pix < n
    assign rem2    = {r_rem, 1'b0};
    assign div_ge  = rem2 >= r_n;
    assign rem_sub = rem2 - r_n;

    assign pix_next = r_pix + rppg_pkg::IDX_W'(1);
    assign pix_last = ({1'b0, r_pix} == (r_n - rppg_pkg::CNT_W'(1)));

    assign hue_base = r_spread ? r_q : {{(rppg_pkg::COLOR_W-rppg_pkg::IDX_W){1'b0}}, r_pix};
    assign hue      = hue_base + r_frame[rppg_pkg::COLOR_W-1:0];

    assign out_free = !r_out_valid || i_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_num    <= rppg_pkg::NUM_PIXELS_RESET;
            r_cfg_spread <= 1'b0;
            r_frame      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rppg_pkg::CFG_NUM_PIXELS: r_cfg_num    <= i_cfg_data;
                    rppg_pkg::CFG_SPREAD:     r_cfg_spread <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.start) begin
                r_frame <= n_frame_start;
            end else if (i_cmd.finish) begin
                r_frame <= r_done ? '0 : r_frame + rppg_pkg::FRAME_W'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_pix_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n       <= n_clamp;
            r_spread  <= r_cfg_spread;
            r_done    <= n_done_start;
            r_pix     <= '0;
            r_rem     <= '0;
            r_q       <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.advance) begin
            r_pix     <= pix_next;
            r_rem     <= pix_next;
            r_q       <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= div_ge ? rem_sub[rppg_pkg::IDX_W-1:0] : rem2[rppg_pkg::IDX_W-1:0];
            r_q       <= {r_q[rppg_pkg::COLOR_W-2:0], div_ge};
            r_div_cnt <= r_div_cnt + rppg_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.load) begin
            r_out_idx  <= r_pix;
            r_out_rgb  <= rppg_pkg::color_wheel(hue);
            r_out_last <= pix_last;
            r_out_done <= r_done;
        end
    end

    assign o_status.spread_cfg = r_cfg_spread;
    assign o_status.spread     = r_spread;
    assign o_status.div_last   = (r_div_cnt == rppg_pkg::DIV_CNT_W'(rppg_pkg::DIV_STEPS - 1));
    assign o_status.out_free   = out_free;
    assign o_status.pix_last   = pix_last;

    assign o_pix_valid   = r_out_valid;
    assign o_pixel_index = r_out_idx;
    assign o_red         = r_out_rgb.red;
    assign o_green       = r_out_rgb.green;
    assign o_blue        = r_out_rgb.blue;
    assign o_last_pixel  = r_out_last;
    assign o_run_done    = r_out_done;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the rainbow pixel pattern generator: directed table, then random frames
// depends on rppg_pkg, rppg_req_if, rppg_pix_if and rainbow_pixel_pattern_generator

module testbench;

    localparam int RING_MAX       = 64;
    localparam int PLAIN_RUN      = 256;
    localparam int SPREAD_RUN     = 256 * 5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int HOLD_OFF       = 300;

    typedef struct packed {
        logic [rppg_pkg::IDX_W-1:0]   pixel_index;
        logic [rppg_pkg::COLOR_W-1:0] red;
        logic [rppg_pkg::COLOR_W-1:0] green;
        logic [rppg_pkg::COLOR_W-1:0] blue;
        logic                         last_pixel;
        logic                         run_done;
    } t_pix;

    typedef enum logic {
        ROW_CFG,
        ROW_FRAME
    } t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [rppg_pkg::CFG_IDX_W-1:0]  idx;
        logic [rppg_pkg::CFG_DATA_W-1:0] data;
        logic                            restart;
        bit                              typed;
        t_pix                            first;
    } t_stim_row;

    // pixel 0 right after a restart always has hue 0, full red
    localparam t_pix RED_ALONE = '{6'd0, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0};
    localparam t_pix RED_FIRST = '{6'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0};
    localparam t_pix NO_PIX    = '0;

    t_stim_row directed_rows [24] = '{
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b1, RED_FIRST},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd1,   1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b1, 1'b1, RED_ALONE},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b1, 1'b1, RED_ALONE},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd127, 1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd65,  1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_SPREAD,     7'd1,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd64,  1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b1, 1'b1, RED_FIRST},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd3,   1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd7,   1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd63,  1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_SPREAD,     7'd0,   1'b0, 1'b0, NO_PIX},
        '{ROW_CFG,   rppg_pkg::CFG_NUM_PIXELS, 7'd64,  1'b0, 1'b0, NO_PIX},
        '{ROW_FRAME, rppg_pkg::CFG_NUM_PIXELS, 7'd0,   1'b1, 1'b1, RED_FIRST}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [rppg_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [rppg_pkg::CFG_DATA_W-1:0] cfg_data;

    rppg_req_if frame_req();
    rppg_pix_if pix_out();

    rainbow_pixel_pattern_generator #(
        .MAX_PIXELS (RING_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (frame_req),
        .o_pix      (pix_out)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the generator state
    logic [rppg_pkg::FRAME_W-1:0] frame_ctr  = '0;
    logic [rppg_pkg::CNT_W-1:0]   cfg_pixels = rppg_pkg::NUM_PIXELS_RESET;
    logic                         cfg_spread = 1'b0;

    t_pix expected_pixels [$];
    int   fail_count  = 0;
    int   idle_pct    = 19;
    int   hold_cycles = 0;

    // colors of one frame; returns the number of pixels it yields
    function automatic int unsigned rainbow_frame(input logic restart);
        int unsigned n, j, hue, p;
        bit          done;
        t_pix        pix;
        n = cfg_pixels;
        if (n < 1) n = 1;
        if (n > RING_MAX) n = RING_MAX;
        if (restart) frame_ctr = '0;
        j = frame_ctr;
        done = cfg_spread ? (j >= SPREAD_RUN - 1) : (j >= PLAIN_RUN - 1);
        for (int unsigned i = 0; i < n; i++) begin
            hue = (cfg_spread ? (i * 256 / n + j) : (i + j)) & 255;
            p   = 255 - hue;
            pix.pixel_index = rppg_pkg::IDX_W'(i);
            if (p < 85) begin
                pix.red   = rppg_pkg::COLOR_W'(255 - 3 * p);
                pix.green = '0;
                pix.blue  = rppg_pkg::COLOR_W'(3 * p);
            end else if (p < 170) begin
                p = p - 85;
                pix.red   = '0;
                pix.green = rppg_pkg::COLOR_W'(3 * p);
                pix.blue  = rppg_pkg::COLOR_W'(255 - 3 * p);
            end else begin
                p = p - 170;
                pix.red   = rppg_pkg::COLOR_W'(3 * p);
                pix.green = rppg_pkg::COLOR_W'(255 - 3 * p);
                pix.blue  = '0;
            end
            pix.last_pixel = (i == n - 1);
            pix.run_done   = done;
            expected_pixels.push_back(pix);
        end
        frame_ctr = done ? '0 : rppg_pkg::FRAME_W'(j + 1);
        return n;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_pixel(input t_pix got);
        t_pix want;
        if (expected_pixels.size() == 0) begin
            $error("pixel %0d arrived with no frame pending", got.pixel_index);
            fail_count++;
        end else begin
            want = expected_pixels.pop_front();
            compare_field("pixel_index", want.pixel_index, got.pixel_index);
            compare_field("red",         want.red,         got.red);
            compare_field("green",       want.green,       got.green);
            compare_field("blue",        want.blue,        got.blue);
            compare_field("last_pixel",  want.last_pixel,  got.last_pixel);
            compare_field("run_done",    want.run_done,    got.run_done);
        end
    endfunction

    // register writes only once every pending pixel is out
    task automatic write_cfg(input logic [rppg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rppg_pkg::CFG_DATA_W-1:0] data);
        frame_req.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        if (idx == rppg_pkg::CFG_NUM_PIXELS) cfg_pixels = data;
        else cfg_spread = data[0];
    endtask

    // valid stays high across back-to-back requests, lowered only for a gap
    task automatic send_frame(input logic restart, input bit typed, input t_pix typed_first);
        int unsigned cnt;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            frame_req.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_req.valid   <= 1'b1;
        frame_req.restart <= restart;
        do @(posedge i_clk); while (!frame_req.ready);
        cnt = rainbow_frame(restart);
        if (typed) expected_pixels[expected_pixels.size() - cnt] = typed_first;
    endtask

    task automatic run_frames(input int count, input int restart_pct, input int hold_at);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) hold_cycles = HOLD_OFF;
            send_frame($urandom_range(99) < restart_pct, 1'b0, NO_PIX);
        end
    endtask

    initial begin : pixel_sink
        t_pix got;
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pix_out.valid && pix_out.ready) begin
                got = '{pix_out.pixel_index, pix_out.red, pix_out.green, pix_out.blue,
                        pix_out.last_pixel, pix_out.run_done};
                check_pixel(got);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((frame_req.valid && frame_req.ready) || (pix_out.valid && pix_out.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= rppg_pkg::CFG_NUM_PIXELS;
        cfg_data          <= '0;
        frame_req.valid   <= 1'b0;
        frame_req.restart <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < $size(directed_rows); r++) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_cfg(directed_rows[r].idx, directed_rows[r].data);
            else
                send_frame(directed_rows[r].restart, directed_rows[r].typed,
                           directed_rows[r].first);
        end

        // plain run long enough to cross a run boundary, receiver held off once
        write_cfg(rppg_pkg::CFG_NUM_PIXELS, 7'($urandom_range(2, 8)));
        run_frames(260, 0, 40);

        // no idling on either side, pixel count anywhere in the register range
        idle_pct = 0;
        write_cfg(rppg_pkg::CFG_NUM_PIXELS, 7'($urandom_range(0, 127)));
        run_frames(20, 10, -1);
        idle_pct = 19;

        // spread mode, upper data bits of the mode write are don't-care
        write_cfg(rppg_pkg::CFG_SPREAD, {6'($urandom_range(63)), 1'b1});
        write_cfg(rppg_pkg::CFG_NUM_PIXELS, 7'd64);
        run_frames(8, 25, -1);
        write_cfg(rppg_pkg::CFG_NUM_PIXELS, 7'($urandom_range(1, 20)));
        run_frames(30, 10, -1);

        // back to plain mode with the counter carried over from spread mode
        write_cfg(rppg_pkg::CFG_SPREAD, {6'($urandom_range(63)), 1'b0});
        run_frames(5, 0, -1);

        frame_req.valid <= 1'b0;
        cfg_we          <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rppg_pkg.sv
sv/rppg_req_if.sv
sv/rppg_pix_if.sv
sv/rppg_ctrl.sv
sv/rppg_datapath.sv
sv/rainbow_pixel_pattern_generator.sv
bench/testbench.sv
